### rtl/core/convex_hull_gift_wrap_top_macros.svh
// assertion macros for the convex hull gift wrap block
// no dependencies; included by the port checker
`ifndef CONVEX_HULL_GIFT_WRAP_TOP_MACROS_SVH
`define CONVEX_HULL_GIFT_WRAP_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define CHGW_AST_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("chgw same-cycle check failed");

// next-cycle implication, disabled while reset is held
`define CHGW_AST_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("chgw next-cycle check failed");

`endif

### rtl/core/chgw_pkg.sv
// shared constants for the convex hull gift wrap block
// no dependencies
package chgw_pkg;

  localparam int MAX_POINTS_DEF = 32;
  localparam int COORD_BITS_DEF = 16;

endpackage

### rtl/core/chgw_cross.sv
// registered 2d cross product sign test for the gift wrap scan
// depends on chgw_pkg
module chgw_cross
  import chgw_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS-1:0] h_x,
  input  logic signed [COORD_BITS-1:0] h_y,
  input  logic signed [COORD_BITS-1:0] c_x,
  input  logic signed [COORD_BITS-1:0] c_y,
  input  logic signed [COORD_BITS-1:0] p_x,
  input  logic signed [COORD_BITS-1:0] p_y,
  output logic                         pos
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;

  logic signed [DW-1:0] cx, cy, px, py;
  logic signed [PW-1:0] prod_a_r, prod_b_r;
  logic signed [SW-1:0] diff;

  // differences from the current hull point, one bit wider
  assign cx = DW'(c_x) - DW'(h_x);
  assign cy = DW'(c_y) - DW'(h_y);
  assign px = DW'(p_x) - DW'(h_x);
  assign py = DW'(p_y) - DW'(h_y);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_a_r <= cx * py;
      prod_b_r <= px * cy;
    end
  end

  assign diff = SW'(prod_a_r) - SW'(prod_b_r);
  assign pos  = !diff[SW-1] && (diff != '0);

endmodule

### rtl/core/convex_hull_gift_wrap_top.sv
// top level of the convex hull gift wrap block: point store, scan sequencer, outputs
// depends on chgw_pkg and chgw_cross
//
// points are loaded one per cycle through start/busy; each accepted request stores
// one signed (x,y) point, and a request with in_last_point set closes the set and
// starts the wrap. points beyond MAX_POINTS are dropped but their last flag still
// counts. the wrap begins at the first stored point of least x and emits hull
// vertices in wrap order on a one-cycle out_valid strobe; the receiver cannot stall,
// so every strobe must be taken. the final vertex carries out_last_vertex, and
// out_truncated as well when MAX_POINTS vertices went out without closing the hull.
// with more than one point stored, the wrap opens with a read of point 1, then scans
// every stored point after point 0 for each hull vertex and ends it in an emit step,
// paced by the single read port of the point memory and the two-step multiply then
// compare of the cross product unit; a lone point goes out without a scan. busy stays
// high for the whole wrap; the last strobe shows in the first cycle after busy falls,
// and a new point may be accepted in that cycle.
module convex_hull_gift_wrap_top
  import chgw_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_x,
  input  logic signed [COORD_BITS-1:0] in_y,
  input  logic                         in_last_point,
  output logic                         out_valid,
  output logic signed [COORD_BITS-1:0] out_hull_x,
  output logic signed [COORD_BITS-1:0] out_hull_y,
  output logic                         out_last_vertex,
  output logic                         out_truncated
);

  // counters hold 0..MAX_POINTS, indexes 0..MAX_POINTS-1
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int PT_W  = 2 * COORD_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,   // loading points
    ST_FIRST,  // read of point 1 after the last write has landed
    ST_MUL,    // read data valid, products latched
    ST_CMP,    // cross product sign known, candidate update
    ST_EMIT    // candidate is the next hull point
  } state_t;

  state_t state_r;

  // point memory, x in the upper half
  logic [PT_W-1:0] pt_mem_r [MAX_POINTS];
  logic [PT_W-1:0] rd_data_r;
  logic            rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic            wr_en;

  logic [CNT_W-1:0] load_cnt_r;
  logic [CNT_W-1:0] npts_r;
  logic [CNT_W-1:0] scan_r;
  logic [CNT_W-1:0] emitted_r;
  logic [CNT_W-1:0] scan_inc;

  // register copies of the points the scan compares against
  logic signed [COORD_BITS-1:0] h_x_r, h_y_r;      // current hull point
  logic signed [COORD_BITS-1:0] c_x_r, c_y_r;      // candidate
  logic signed [COORD_BITS-1:0] s_x_r, s_y_r;      // start point
  logic signed [COORD_BITS-1:0] p0_x_r, p0_y_r;    // stored point 0
  logic signed [COORD_BITS-1:0] min_x_r, min_y_r;  // least x seen so far

  logic signed [COORD_BITS-1:0] p_x, p_y;
  logic signed [COORD_BITS-1:0] nmin_x, nmin_y;
  logic signed [COORD_BITS-1:0] np0_x, np0_y;

  logic accept, room, take_min, first_pt;
  logic cross_pos, same_hc, closed, cap_hit;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign room   = (load_cnt_r < CNT_W'(MAX_POINTS));
  assign wr_en  = accept && room;
  assign first_pt = (load_cnt_r == '0);

  // strict less-than keeps the first point of least x
  assign take_min = room && (first_pt || (in_x < min_x_r));
  assign nmin_x   = take_min ? in_x : min_x_r;
  assign nmin_y   = take_min ? in_y : min_y_r;
  assign np0_x    = (room && first_pt) ? in_x : p0_x_r;
  assign np0_y    = (room && first_pt) ? in_y : p0_y_r;

  assign p_x = $signed(rd_data_r[PT_W-1:COORD_BITS]);
  assign p_y = $signed(rd_data_r[COORD_BITS-1:0]);

  assign scan_inc = scan_r + CNT_W'(1);
  assign same_hc  = (h_x_r == c_x_r) && (h_y_r == c_y_r);
  assign closed   = (c_x_r == s_x_r) && (c_y_r == s_y_r);
  assign cap_hit  = (emitted_r == CNT_W'(MAX_POINTS - 1));

  // read port: one point per scan step
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_r[IDX_W-1:0];
    unique case (state_r)
      ST_FIRST: begin
        rd_en   = 1'b1;
        rd_addr = scan_r[IDX_W-1:0];
      end
      ST_CMP: begin
        rd_en   = (scan_inc < npts_r);
        rd_addr = scan_inc[IDX_W-1:0];
      end
      ST_EMIT: begin
        rd_en   = (npts_r > CNT_W'(1));
        rd_addr = IDX_W'(1);
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = scan_r[IDX_W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pt_mem_r[load_cnt_r[IDX_W-1:0]] <= {in_x, in_y};
    end
    if (rd_en) begin
      rd_data_r <= pt_mem_r[rd_addr];
    end
  end

  chgw_cross #(
    .COORD_BITS(COORD_BITS)
  ) u_cross (
    .clk (clk),
    .en  (state_r == ST_MUL),
    .h_x (h_x_r),
    .h_y (h_y_r),
    .c_x (c_x_r),
    .c_y (c_y_r),
    .p_x (p_x),
    .p_y (p_y),
    .pos (cross_pos)
  );

  // sequencer, point registers and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      load_cnt_r <= '0;
      npts_r     <= '0;
      scan_r     <= '0;
      emitted_r  <= '0;
      out_valid  <= 1'b0;
    end else begin
      // one strobe per emit cycle
      out_valid <= (state_r == ST_EMIT);
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (room) begin
              min_x_r    <= nmin_x;
              min_y_r    <= nmin_y;
              p0_x_r     <= np0_x;
              p0_y_r     <= np0_y;
            end
            if (in_last_point) begin
              // close the set: start from the least-x point, candidate is point 0
              load_cnt_r <= '0;
              npts_r     <= room ? (load_cnt_r + CNT_W'(1)) : load_cnt_r;
              h_x_r      <= nmin_x;
              h_y_r      <= nmin_y;
              s_x_r      <= nmin_x;
              s_y_r      <= nmin_y;
              c_x_r      <= np0_x;
              c_y_r      <= np0_y;
              emitted_r  <= '0;
              scan_r     <= CNT_W'(1);
              if (room ? (load_cnt_r != '0) : (load_cnt_r > CNT_W'(1))) begin
                state_r <= ST_FIRST;
              end else begin
                state_r <= ST_EMIT;
              end
            end else if (room) begin
              load_cnt_r <= load_cnt_r + CNT_W'(1);
            end
          end
        end
        ST_FIRST: begin
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          state_r <= ST_CMP;
        end
        ST_CMP: begin
          if (same_hc || cross_pos) begin
            c_x_r <= p_x;
            c_y_r <= p_y;
          end
          scan_r <= scan_inc;
          if (scan_inc < npts_r) begin
            state_r <= ST_MUL;
          end else begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          out_hull_x      <= h_x_r;
          out_hull_y      <= h_y_r;
          out_last_vertex <= closed || cap_hit;
          out_truncated   <= !closed && cap_hit;
          emitted_r       <= emitted_r + CNT_W'(1);
          if (closed || cap_hit) begin
            state_r <= ST_IDLE;
          end else begin
            // candidate becomes the next hull point, restart the scan
            h_x_r  <= c_x_r;
            h_y_r  <= c_y_r;
            c_x_r  <= p0_x_r;
            c_y_r  <= p0_y_r;
            scan_r <= CNT_W'(1);
            if (npts_r > CNT_W'(1)) begin
              state_r <= ST_MUL;
            end else begin
              state_r <= ST_EMIT;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/chgw_checker.sv
// port-level checker for the convex hull gift wrap block, with its bind
// depends on convex_hull_gift_wrap_top_macros.svh
`include "convex_hull_gift_wrap_top_macros.svh"

module chgw_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_last_point,
  input logic out_valid,
  input logic out_last_vertex,
  input logic out_truncated
);

  // a point that does not close the set never starts a wrap
  `CHGW_AST_NEXT(a_load_stays_idle, clk, rst_n, start && !busy && !in_last_point, !busy)

  // closing the set always starts a wrap
  `CHGW_AST_NEXT(a_last_starts_wrap, clk, rst_n, start && !busy && in_last_point, busy)

  // truncation only ever flags the final vertex
  `CHGW_AST_SAME(a_trunc_is_last, clk, rst_n, out_valid && out_truncated, out_last_vertex)

  // the final vertex shows just as the block frees up, others while it is working
  `CHGW_AST_SAME(a_last_frees, clk, rst_n, out_valid, out_last_vertex == !busy)

endmodule

bind convex_hull_gift_wrap_top chgw_checker u_chgw_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_last_point   (in_last_point),
  .out_valid       (out_valid),
  .out_last_vertex (out_last_vertex),
  .out_truncated   (out_truncated)
);

### verif/tb_top.sv
`timescale 1ns / 1ps
// testbench for convex_hull_gift_wrap_top: drives point requests, predicts each hull
// and checks every vertex strobe; depends on chgw_pkg and the block's rtl
module tb_top;
  import chgw_pkg::*;

  localparam int NPTS          = MAX_POINTS_DEF;
  localparam int CW            = COORD_BITS_DEF;
  // worst run is far below this: ~260 requests with their idle gaps, plus one wrap
  // per set
  localparam int LIMIT         = 1_000_000;
  localparam int DRAIN         = 40;
  localparam int RANDOM_POINTS = 220;
  localparam int MAX_GAP       = 17;
  localparam int BIG_SETS      = 3;

  localparam logic signed [CW-1:0] CMIN = 16'sh8000;
  localparam logic signed [CW-1:0] CMAX = 16'sh7fff;

  // one hull vertex as it leaves the block
  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 last_vertex;
    logic                 truncated;
  } vertex_t;

  // one point request; fixed rows carry their single vertex typed in
  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    bit                   last;
    bit                   fixed;
    logic signed [CW-1:0] fx;
    logic signed [CW-1:0] fy;
    bit                   flv;
    bit                   ftr;
  } stim_row_t;

  // how random coordinates are spread
  typedef enum {SPREAD_FULL, SPREAD_TIGHT, SPREAD_CORNERS} spread_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [CW-1:0] in_x = '0;
  logic signed [CW-1:0] in_y = '0;
  logic                 in_last_point = 1'b0;
  logic                 out_valid;
  logic signed [CW-1:0] out_hull_x;
  logic signed [CW-1:0] out_hull_y;
  logic                 out_last_vertex;
  logic                 out_truncated;

  // typed expectation travelling alongside the request on the pins
  bit                   drv_fixed = 1'b0;
  vertex_t              drv_fixed_v;

  bit                   burst = 1'b0;
  int                   cycle_cnt = 0;
  int                   mismatches = 0;

  // predictor state: its own copy of the point store
  logic signed [CW-1:0] pts_x [NPTS];
  logic signed [CW-1:0] pts_y [NPTS];
  int                   pts_n = 0;
  vertex_t              wrap_out [$];
  vertex_t              vertices_due [$];
  vertex_t              want_v;

  // directed requests: lone points echo straight back, so those are typed in
  stim_row_t directed [23] = '{
    // lone points at the coordinate extremes, zero and all-ones
    '{CMIN, CMAX, 1, 1, CMIN, CMAX, 1, 0},
    '{CMAX, CMIN, 1, 1, CMAX, CMIN, 1, 0},
    '{16'sd0, 16'sd0, 1, 1, 16'sd0, 16'sd0, 1, 0},
    '{-16'sd1, -16'sd1, 1, 1, -16'sd1, -16'sd1, 1, 0},
    // full-range square: widest cross products
    '{CMAX, CMIN, 0, 0, 0, 0, 0, 0},
    '{CMAX, CMAX, 0, 0, 0, 0, 0, 0},
    '{CMIN, CMAX, 0, 0, 0, 0, 0, 0},
    '{CMIN, CMIN, 1, 0, 0, 0, 0, 0},
    // duplicates compare equal by value
    '{16'sd100, -16'sd200, 0, 0, 0, 0, 0, 0},
    '{16'sd100, -16'sd200, 0, 0, 0, 0, 0, 0},
    '{16'sd100, -16'sd200, 1, 0, 0, 0, 0, 0},
    // triangle with an interior point and two on edges
    '{16'sd0, 16'sd0, 0, 0, 0, 0, 0, 0},
    '{16'sd10, 16'sd0, 0, 0, 0, 0, 0, 0},
    '{16'sd5, 16'sd5, 0, 0, 0, 0, 0, 0},
    '{16'sd2, 16'sd1, 0, 0, 0, 0, 0, 0},
    '{16'sd5, 16'sd0, 0, 0, 0, 0, 0, 0},
    '{16'sd0, 16'sd10, 1, 0, 0, 0, 0, 0},
    // tie on least x: the first such point starts the wrap
    '{-16'sd5, 16'sd3, 0, 0, 0, 0, 0, 0},
    '{-16'sd5, -16'sd3, 0, 0, 0, 0, 0, 0},
    '{16'sd7, 16'sd0, 1, 0, 0, 0, 0, 0},
    // all points on one vertical line
    '{16'sd0, 16'sd1, 0, 0, 0, 0, 0, 0},
    '{16'sd0, 16'sd2, 0, 0, 0, 0, 0, 0},
    '{16'sd0, 16'sd0, 1, 0, 0, 0, 0, 0}
  };

  convex_hull_gift_wrap_top #(
    .MAX_POINTS(NPTS),
    .COORD_BITS(CW)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_x           (in_x),
    .in_y           (in_y),
    .in_last_point  (in_last_point),
    .out_valid      (out_valid),
    .out_hull_x     (out_hull_x),
    .out_hull_y     (out_hull_y),
    .out_last_vertex(out_last_vertex),
    .out_truncated  (out_truncated)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic bit same_pt(int a, int b);
    return pts_x[a] == pts_x[b] && pts_y[a] == pts_y[b];
  endfunction

  // signed area of (h->c) x (h->p); positive means p lies left of h->c
  function automatic longint turn(int h, int c, int p);
    longint cx, cy, px, py;
    cx = longint'(pts_x[c]) - longint'(pts_x[h]);
    cy = longint'(pts_y[c]) - longint'(pts_y[h]);
    px = longint'(pts_x[p]) - longint'(pts_x[h]);
    py = longint'(pts_y[p]) - longint'(pts_y[h]);
    return cx * py - px * cy;
  endfunction

  // store one point; on the last point of a set, wrap it into wrap_out
  task automatic store_and_wrap(input logic signed [CW-1:0] px, input logic signed [CW-1:0] py,
                                input bit pl);
    int      i, s, h, c;
    vertex_t v;
    wrap_out.delete();
    // a full store drops the point but still honours its last flag
    if (pts_n < NPTS) begin
      pts_x[pts_n] = px;
      pts_y[pts_n] = py;
      pts_n++;
    end
    if (!pl) return;
    s = 0;
    for (i = 1; i < pts_n; i++) begin
      if (pts_x[i] < pts_x[s]) s = i;
    end
    h = s;
    forever begin
      v.x = pts_x[h];
      v.y = pts_y[h];
      v.last_vertex = 1'b0;
      v.truncated = 1'b0;
      c = 0;
      for (i = 1; i < pts_n; i++) begin
        if (same_pt(h, c) || turn(h, c, i) > 0) c = i;
      end
      h = c;
      // closed when the next vertex is the start point by value
      if (same_pt(h, s)) begin
        v.last_vertex = 1'b1;
        wrap_out = {wrap_out, v};
        break;
      end
      // emission cap reached without closing
      if (wrap_out.size() + 1 >= NPTS) begin
        v.last_vertex = 1'b1;
        v.truncated = 1'b1;
        wrap_out = {wrap_out, v};
        break;
      end
      wrap_out = {wrap_out, v};
    end
    pts_n = 0;
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string what, input logic signed [31:0] got,
                               input logic signed [31:0] want);
    $display("cycle %0d: %s got %0d expected %0d", cycle_cnt, what, got, want);
    mismatches++;
  endtask

  // results first, then the request taken at this edge, so a new set never
  // overtakes the tail of the previous hull in the queue
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (vertices_due.size() == 0) begin
          note_mismatch("vertex x with nothing pending", 32'(out_hull_x), 0);
        end else begin
          want_v = vertices_due.pop_front();
          if (out_hull_x !== want_v.x)
            note_mismatch("hull_x", 32'(out_hull_x), 32'(want_v.x));
          if (out_hull_y !== want_v.y)
            note_mismatch("hull_y", 32'(out_hull_y), 32'(want_v.y));
          if (out_last_vertex !== want_v.last_vertex)
            note_mismatch("last_vertex", 32'(out_last_vertex), 32'(want_v.last_vertex));
          if (out_truncated !== want_v.truncated)
            note_mismatch("truncated", 32'(out_truncated), 32'(want_v.truncated));
        end
      end
      if (start && !busy) begin
        store_and_wrap(in_x, in_y, in_last_point);
        if (drv_fixed) begin
          vertices_due = {vertices_due, drv_fixed_v};
        end else begin
          vertices_due = {vertices_due, wrap_out};
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic logic signed [CW-1:0] pick_coord(spread_t sp);
    case (sp)
      SPREAD_TIGHT: begin
        return CW'(int'($urandom_range(0, 6)) - 3);
      end
      SPREAD_CORNERS: begin
        case ($urandom_range(0, 5))
          0: return CMIN;
          1: return CMAX;
          2: return -16'sd1;
          3: return 16'sd0;
          4: return 16'sd1;
          default: return CMIN + 16'sd1;
        endcase
      end
      default: begin
        return CW'($urandom);
      end
    endcase
  endfunction

  // one request: optional idle gap, then hold start until the block takes it;
  // enters and leaves on a falling edge, start stays high between back-to-back requests
  task automatic send_point(input stim_row_t r);
    int gap;
    gap = burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_x <= r.x;
    in_y <= r.y;
    in_last_point <= r.last;
    drv_fixed <= r.fixed;
    drv_fixed_v <= '{r.fx, r.fy, r.flv, r.ftr};
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // timeout: also catches vertices that never arrive
  initial begin
    while (cycle_cnt < LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int        i, k, size, big_left, points_sent;
    spread_t   sp;
    stim_row_t r;

    big_left = BIG_SETS;
    points_sent = 0;

    // synchronous reset, released on a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part
    foreach (directed[n]) send_point(directed[n]);

    // random sets: mostly small, a few past the store size to hit the drop path
    while (points_sent < RANDOM_POINTS) begin
      k = $urandom_range(0, 9);
      // roughly one set in four goes without any idle gaps
      burst = ($urandom_range(0, 3) == 0);
      if (k == 9 && big_left > 0) begin
        big_left--;
        size = $urandom_range(NPTS - 1, NPTS + 8);
        sp = SPREAD_FULL;
      end else if (k >= 7) begin
        size = $urandom_range(9, 20);
        sp = SPREAD_FULL;
      end else if (k >= 5) begin
        // crowded grid: duplicates and collinear runs
        size = $urandom_range(2, 10);
        sp = SPREAD_TIGHT;
      end else if (k == 4) begin
        size = $urandom_range(2, 8);
        sp = SPREAD_CORNERS;
      end else begin
        size = $urandom_range(1, 8);
        sp = SPREAD_FULL;
      end
      for (i = 0; i < size; i++) begin
        r = '{pick_coord(sp), pick_coord(sp), (i == size - 1), 1'b0, '0, '0, 1'b0, 1'b0};
        send_point(r);
      end
      points_sent += (size > NPTS) ? NPTS : size;
    end

    start <= 1'b0;

    // wait out the last hull, then a short tail for stray strobes
    while (vertices_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
